// ===== hdl/cmaf_pkg.sv =====
`default_nettype none

package cmaf_pkg;

  // Storage size of each list; the parameter LIST_ENTRIES limits how many are compared.
  localparam int MAX_ENTRIES = 8;
  localparam int LIST_ENTRIES_DEF = 8;

  localparam int CAN_ID_W = 16;
  localparam int SUB_ID_W = 6;
  localparam int COUNT_W = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 16;

  // Frame type codes from the top two bits of header byte 0.
  localparam logic [1:0] KIND_LONG_START = 2'b10;
  localparam logic [1:0] KIND_LONG_CONT = 2'b11;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAN_IDS_LOW = 3'd0,
    REG_CAN_IDS_HIGH = 3'd1,
    REG_CAN_COUNT = 3'd2,
    REG_FUNCTION_IDS = 3'd3,
    REG_FUNCTION_COUNT = 3'd4,
    REG_DEVICE_IDS = 3'd5,
    REG_DEVICE_COUNT = 3'd6
  } cfg_reg_t;

  // Filter lists as seen by the compare stage, with clamped entry counts.
  typedef struct packed {
    logic [MAX_ENTRIES-1:0][CAN_ID_W-1:0] can_ids;
    logic [MAX_ENTRIES-1:0][SUB_ID_W-1:0] fn_ids;
    logic [MAX_ENTRIES-1:0][SUB_ID_W-1:0] dev_ids;
    logic [COUNT_W-1:0] can_used;
    logic [COUNT_W-1:0] fn_used;
    logic [COUNT_W-1:0] dev_used;
  } filter_cfg_t;

  // Decoded frame after the first stage.
  typedef struct packed {
    logic [CAN_ID_W-1:0] can_id;
    logic present;
    logic [SUB_ID_W-1:0] fid;
    logic [SUB_ID_W-1:0] did;
  } frame_t;

endpackage

`default_nettype wire

// ===== hdl/can_message_acceptance_filter.sv =====
// CAN message acceptance filter.
// Input channel in_*: one frame per transaction, in_tdata carries can_id,
// header_byte0, header_byte1, header_byte2 and header_byte3 from the lowest bit up.
// Output channel out_*: one result per frame, in the order the frames arrived.
// Configuration channel cfg_*: writes register cfg_index with cfg_data; it is
// always ready and should only be used while no frame is in flight.
// Throughput is one frame per cycle while the receiver takes results. The block
// has three register stages (decode, list compare, result), which each frame
// passes in that order before its result is shown on out_tvalid.
// The compare stage checks the first LIST_ENTRIES entries of all three lists in parallel.
// Reset empties the pipeline and clears all lists, so every frame is accepted
// until a count register is written.
// When the receiver stalls, the result stage holds and each stage keeps taking
// new frames until it holds a valid frame itself; in_tready drops only when
// all three stages are full.
`default_nettype none

module can_message_acceptance_filter #(
  parameter int LIST_ENTRIES = cmaf_pkg::LIST_ENTRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // can_id[15:0], header_byte0[23:16], header_byte1[31:24],
  // header_byte2[39:32], header_byte3[47:40]
  input  wire logic [cmaf_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // accept[0], function_id[6:1], device_id[12:7], zero fill [15:13]
  output logic [cmaf_pkg::OUT_DATA_W-1:0]         out_tdata,
  // ids_present[0]
  output logic                                    out_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cmaf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [cmaf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  cmaf_pkg::filter_cfg_t   cfg;
  logic                    s1_valid, s1_ready;
  cmaf_pkg::frame_t        s1_frame;
  logic                    s2_valid, s3_ready;
  cmaf_pkg::frame_t        s2_frame;
  logic [LIST_ENTRIES-1:0] s2_can_hit, s2_fn_hit, s2_dev_hit;
  logic [2:0]              s2_empty;
  logic                    can_ok, fn_ok, dev_ok;
  logic                    out_valid_r;
  logic                    accept_r;
  logic                    present_r;
  logic [cmaf_pkg::SUB_ID_W-1:0] fid_r, did_r;

  assign cfg_ready = 1'b1;

  cmaf_cfg_regs #(
    .LIST_ENTRIES(LIST_ENTRIES)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cmaf_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_frame (s1_frame)
  );

  cmaf_match #(
    .LIST_ENTRIES(LIST_ENTRIES)
  ) u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .up_valid   (s1_valid),
    .up_ready   (s1_ready),
    .up_frame   (s1_frame),
    .dn_valid   (s2_valid),
    .dn_ready   (s3_ready),
    .dn_frame   (s2_frame),
    .dn_can_hit (s2_can_hit),
    .dn_fn_hit  (s2_fn_hit),
    .dn_dev_hit (s2_dev_hit),
    .dn_empty   (s2_empty)
  );

  // Reduce the hit vectors; a continuation frame fails any non-empty function or device ID list.
  always_comb begin
    can_ok = s2_empty[0] || (|s2_can_hit);
    fn_ok = s2_empty[1] || (s2_frame.present && (|s2_fn_hit));
    dev_ok = s2_empty[2] || (s2_frame.present && (|s2_dev_hit));
  end

  assign s3_ready = !out_valid_r || out_tready;

  // Result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      accept_r <= can_ok && fn_ok && dev_ok;
      present_r <= s2_frame.present;
      fid_r <= s2_frame.fid;
      did_r <= s2_frame.did;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = present_r;
  assign out_tdata = {3'b000, did_r, fid_r, accept_r};

`ifndef SYNTHESIS
  // A frame without IDs reports zero IDs.
  a_no_ids_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !present_r) |-> (fid_r == '0 && did_r == '0))
    else $error("IDs reported for a frame without IDs");

  // An accepted input transaction fills the decode stage.
  a_input_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid)
    else $error("accepted frame lost at decode stage");

  // The pipeline back-pressures only when the result stage is occupied.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result stage");

  // A stalled result stays valid.
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

// ===== hdl/cmaf_cfg_regs.sv =====
`default_nettype none

module cmaf_cfg_regs #(
  parameter int LIST_ENTRIES = cmaf_pkg::LIST_ENTRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               wr_en,
  input  wire logic [cmaf_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  wire logic [cmaf_pkg::CFG_DATA_W-1:0]    wr_data,
  output cmaf_pkg::filter_cfg_t                   cfg
);

  localparam logic [cmaf_pkg::COUNT_W-1:0] LIMIT = cmaf_pkg::COUNT_W'(LIST_ENTRIES);

  logic [cmaf_pkg::CFG_DATA_W-1:0] can_low_r;
  logic [cmaf_pkg::CFG_DATA_W-1:0] can_high_r;
  logic [cmaf_pkg::COUNT_W-1:0]    can_count_r;
  logic [47:0]                     fn_ids_r;
  logic [cmaf_pkg::COUNT_W-1:0]    fn_count_r;
  logic [47:0]                     dev_ids_r;
  logic [cmaf_pkg::COUNT_W-1:0]    dev_count_r;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      can_low_r <= '0;
      can_high_r <= '0;
      can_count_r <= '0;
      fn_ids_r <= '0;
      fn_count_r <= '0;
      dev_ids_r <= '0;
      dev_count_r <= '0;
    end else if (wr_en) begin
      case (wr_index)
        cmaf_pkg::REG_CAN_IDS_LOW:    can_low_r <= wr_data;
        cmaf_pkg::REG_CAN_IDS_HIGH:   can_high_r <= wr_data;
        cmaf_pkg::REG_CAN_COUNT:      can_count_r <= wr_data[cmaf_pkg::COUNT_W-1:0];
        cmaf_pkg::REG_FUNCTION_IDS:   fn_ids_r <= wr_data[47:0];
        cmaf_pkg::REG_FUNCTION_COUNT: fn_count_r <= wr_data[cmaf_pkg::COUNT_W-1:0];
        cmaf_pkg::REG_DEVICE_IDS:     dev_ids_r <= wr_data[47:0];
        cmaf_pkg::REG_DEVICE_COUNT:   dev_count_r <= wr_data[cmaf_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Present the lists and clamp each count to the compared entries.
  always_comb begin
    cfg.can_ids = {can_high_r, can_low_r};
    cfg.fn_ids = fn_ids_r;
    cfg.dev_ids = dev_ids_r;
    cfg.can_used = (can_count_r > LIMIT) ? LIMIT : can_count_r;
    cfg.fn_used = (fn_count_r > LIMIT) ? LIMIT : fn_count_r;
    cfg.dev_used = (dev_count_r > LIMIT) ? LIMIT : dev_count_r;
  end

endmodule

`default_nettype wire

// ===== hdl/cmaf_decode.sv =====
`default_nettype none

module cmaf_decode (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             up_valid,
  output logic                                  up_ready,
  input  wire logic [cmaf_pkg::IN_DATA_W-1:0]   up_data,
  output logic                                  dn_valid,
  input  wire logic                             dn_ready,
  output cmaf_pkg::frame_t                      dn_frame
);

  logic [7:0]       h0, h1, h2, h3;
  logic [7:0]       b0, b1;
  logic [1:0]       kind;
  cmaf_pkg::frame_t frame;
  logic             valid_r;
  cmaf_pkg::frame_t frame_r;

  // Pick the ID bytes by frame type and extract the function and device IDs.
  always_comb begin
    h0 = up_data[23:16];
    h1 = up_data[31:24];
    h2 = up_data[39:32];
    h3 = up_data[47:40];
    kind = h0[7:6];
    b0 = (kind == cmaf_pkg::KIND_LONG_START) ? h2 : h0;
    b1 = (kind == cmaf_pkg::KIND_LONG_START) ? h3 : h1;
    frame.can_id = up_data[15:0];
    frame.present = (kind != cmaf_pkg::KIND_LONG_CONT);
    frame.fid = frame.present ? b1[5:0] : '0;
    frame.did = frame.present ? {b0[3:0], b1[7:6]} : '0;
  end

  assign up_ready = !valid_r || dn_ready;

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      frame_r <= frame;
    end
  end

  assign dn_valid = valid_r;
  assign dn_frame = frame_r;

endmodule

`default_nettype wire

// ===== hdl/cmaf_match.sv =====
`default_nettype none

module cmaf_match #(
  parameter int LIST_ENTRIES = cmaf_pkg::LIST_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmaf_pkg::filter_cfg_t cfg,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire cmaf_pkg::frame_t      up_frame,
  output logic                       dn_valid,
  input  wire logic                  dn_ready,
  output cmaf_pkg::frame_t           dn_frame,
  output logic [LIST_ENTRIES-1:0]    dn_can_hit,
  output logic [LIST_ENTRIES-1:0]    dn_fn_hit,
  output logic [LIST_ENTRIES-1:0]    dn_dev_hit,
  output logic [2:0]                 dn_empty
);

  logic [LIST_ENTRIES-1:0] can_hit, fn_hit, dev_hit;
  logic [2:0]              empty;
  logic                    valid_r;
  cmaf_pkg::frame_t        frame_r;
  logic [LIST_ENTRIES-1:0] can_hit_r, fn_hit_r, dev_hit_r;
  logic [2:0]              empty_r;

  // Compare against the first LIST_ENTRIES entries of each list in parallel, masking entries not in use.
  always_comb begin
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      can_hit[i] = (cfg.can_ids[i] == up_frame.can_id) &&
                   (cmaf_pkg::COUNT_W'(i) < cfg.can_used);
      fn_hit[i] = (cfg.fn_ids[i] == up_frame.fid) &&
                  (cmaf_pkg::COUNT_W'(i) < cfg.fn_used);
      dev_hit[i] = (cfg.dev_ids[i] == up_frame.did) &&
                   (cmaf_pkg::COUNT_W'(i) < cfg.dev_used);
    end
    empty[0] = (cfg.can_used == '0);
    empty[1] = (cfg.fn_used == '0);
    empty[2] = (cfg.dev_used == '0);
  end

  assign up_ready = !valid_r || dn_ready;

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      frame_r <= up_frame;
      can_hit_r <= can_hit;
      fn_hit_r <= fn_hit;
      dev_hit_r <= dev_hit;
      empty_r <= empty;
    end
  end

  assign dn_valid = valid_r;
  assign dn_frame = frame_r;
  assign dn_can_hit = can_hit_r;
  assign dn_fn_hit = fn_hit_r;
  assign dn_dev_hit = dev_hit_r;
  assign dn_empty = empty_r;

endmodule

`default_nettype wire
